/* sv/srrb_pkg.sv */
// Shared types and constants for the sensor readout reorder and binning block.
package srrb_pkg;

   typedef struct packed {
      logic        func;
      logic [15:0] raw_word;
      logic        frame_last;
   } req_type;

   typedef struct packed {
      logic [15:0] pixel;
      logic        last;
   } rsp_type;

   localparam logic       FUNC_DATA  = 1'b0;
   localparam logic       FUNC_FLUSH = 1'b1;

   localparam logic [1:0] BIN_1X1 = 2'd0;
   localparam logic [1:0] BIN_2X2 = 2'd1;
   localparam logic [1:0] BIN_4X4 = 2'd2;

   localparam logic       REG_BIN_MODE    = 1'b0;
   localparam logic       REG_LINE_PIXELS = 1'b1;

   localparam logic [12:0] LINE_PIXELS_RESET = 13'd3110;
   localparam logic [17:0] PIXEL_MAX         = 18'd65535;

   localparam int unsigned RSP_DEPTH = 4;

endpackage

/* sv/sensor_readout_reorder_bin.sv */
// Sensor readout reorder and binning block: row store, binning adder and result queue.
//
// Usage:
//   req_* carries one item per accepted cycle (req_valid high, req_stall low):
//   a raw sensor word (func data) or a flush tick (func flush). Each word is
//   byte swapped on entry. In 1x1 mode words land at their line place in one
//   bank of a ping-pong row store while the other bank drains one pixel per
//   item; flush ticks drain what remains. In 2x2 and 4x4 modes two or four
//   words are summed and saturated at 65535.
//   rsp_* delivers zero or one pixel per item, accepted when rsp_valid is high
//   and rsp_stall is low.
//   Throughput is one item per cycle while req_stall is low. A result passes the
//   read stage (the synchronous row store read) and then the result queue before
//   rsp_valid. The queue holds four results; req_stall rises when results queued
//   plus the one in the read stage reach four, so a stalled receiver holds the
//   block after at most four pending results. Registers (bin_mode at 0, line_pixels
//   at 4) are written through the APB port; the user must write them only while
//   the block is idle, which the block does not enforce. Synchronous reset clears
//   control state and registers; the row store is not cleared.
module sensor_readout_reorder_bin
   import srrb_pkg::*;
#(
   parameter int MAX_LINE_PIXELS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int STORE_WORDS = 4 * MAX_LINE_PIXELS;
   localparam int AW = $clog2(STORE_WORDS);
   localparam logic [14:0] BANK_WORDS = 15'(2 * MAX_LINE_PIXELS);
   localparam logic [13:0] MAX_L = 14'(MAX_LINE_PIXELS);

   logic [1:0]  bin_mode_ff;
   logic [12:0] line_pixels_ff;

   logic [15:0] store_mem [STORE_WORDS];
   logic [15:0] mem_q_ff;

   logic        write_bank_ff, write_bank_in;
   logic [12:0] write_pos_ff, write_pos_in;
   logic [12:0] read_pos_ff, read_pos_in;
   logic        prev_ready_ff, prev_ready_in;
   logic        frame_ended_ff, frame_ended_in;
   logic [17:0] bin_sum_ff, bin_sum_in;
   logic [1:0]  group_count_ff, group_count_in;

   logic        s1_valid_ff, s1_valid_in;
   logic        s1_from_mem_ff, s1_from_mem_in;
   logic        s1_oob_ff, s1_oob_in;
   logic [15:0] s1_pixel_ff, s1_pixel_in;
   logic        s1_last_ff, s1_last_in;

   rsp_type     rsp_q_ff [RSP_DEPTH];
   logic [1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [2:0]  count_ff, count_in;
   rsp_type     push_item;

   logic        accept, pop, cfg_write;
   logic [15:0] word;
   logic [13:0] l_clamp, l_even, l_eff;
   logic [14:0] row_len, dest, grp2;
   logic        wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic        drain, drain_end, write_end;
   logic [17:0] sum;
   logic [2:0]  cnt, group_size;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;
   assign prdata    = (paddr[2] == REG_LINE_PIXELS) ? {19'd0, line_pixels_ff}
                                                    : {30'd0, bin_mode_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_mode_ff    <= BIN_1X1;
         line_pixels_ff <= LINE_PIXELS_RESET;
      end else if (cfg_write) begin
         if (paddr[2] == REG_LINE_PIXELS) begin
            line_pixels_ff <= pwdata[12:0];
         end else begin
            bin_mode_ff <= pwdata[1:0];
         end
      end
   end

   assign req_stall = ({1'b0, count_ff} + {3'd0, s1_valid_ff}) >= 4'(RSP_DEPTH);
   assign accept    = req_valid && !req_stall;
   assign word      = {req_data.raw_word[7:0], req_data.raw_word[15:8]};

   assign l_clamp = ({1'b0, line_pixels_ff} > MAX_L) ? MAX_L : {1'b0, line_pixels_ff};
   assign l_even  = {l_clamp[13:1], 1'b0};
   assign l_eff   = (l_even < 14'd2) ? 14'd2 : l_even;
   assign row_len = {l_eff, 1'b0};

   assign grp2 = 15'({write_pos_ff[12:2], write_pos_ff[0]});
   assign dest = write_pos_ff[1] ? grp2 : ({1'b0, l_eff} + grp2);

   assign drain_end = ({2'd0, read_pos_ff} + 15'd1) >= row_len;
   assign write_end = ({2'd0, write_pos_ff} + 15'd1) >= row_len;
   assign sum        = bin_sum_ff + {2'd0, word};
   assign cnt        = {1'b0, group_count_ff} + 3'd1;
   assign group_size = (bin_mode_ff == BIN_2X2) ? 3'd2 : 3'd4;

   always_comb begin
      write_bank_in  = write_bank_ff;
      write_pos_in   = write_pos_ff;
      read_pos_in    = read_pos_ff;
      prev_ready_in  = prev_ready_ff;
      frame_ended_in = frame_ended_ff;
      bin_sum_in     = bin_sum_ff;
      group_count_in = group_count_ff;
      s1_valid_in    = 1'b0;
      s1_from_mem_in = 1'b0;
      s1_oob_in      = 1'b0;
      s1_pixel_in    = s1_pixel_ff;
      s1_last_in     = s1_last_ff;
      drain          = 1'b0;
      wr_en          = 1'b0;
      if (accept) begin
         if (bin_mode_ff == BIN_1X1) begin
            drain = prev_ready_ff;
            wr_en = (req_data.func == FUNC_DATA) && (dest < BANK_WORDS);
            if (drain) begin
               s1_valid_in    = 1'b1;
               s1_from_mem_in = 1'b1;
               s1_oob_in      = {2'd0, read_pos_ff} >= BANK_WORDS;
               s1_last_in     = drain_end && frame_ended_ff;
               if (drain_end) begin
                  prev_ready_in  = 1'b0;
                  read_pos_in    = '0;
                  frame_ended_in = 1'b0;
               end else begin
                  read_pos_in = read_pos_ff + 13'd1;
               end
            end
            if (req_data.func == FUNC_DATA) begin
               if (req_data.frame_last || write_end) begin
                  write_pos_in  = '0;
                  write_bank_in = !write_bank_ff;
                  prev_ready_in = 1'b1;
                  read_pos_in   = '0;
                  if (req_data.frame_last) begin
                     frame_ended_in = 1'b1;
                  end
               end else begin
                  write_pos_in = write_pos_ff + 13'd1;
               end
            end
         end else if (req_data.func == FUNC_DATA) begin
            if (req_data.frame_last || (cnt >= group_size)) begin
               s1_valid_in    = 1'b1;
               s1_pixel_in    = (sum > PIXEL_MAX) ? PIXEL_MAX[15:0] : sum[15:0];
               s1_last_in     = req_data.frame_last;
               bin_sum_in     = '0;
               group_count_in = '0;
            end else begin
               bin_sum_in     = sum;
               group_count_in = cnt[1:0];
            end
         end
      end
   end

   assign rd_en   = drain;
   assign wr_addr = write_bank_ff ? (AW'(BANK_WORDS) + AW'(dest)) : AW'(dest);
   assign rd_addr = write_bank_ff ? AW'(read_pos_ff)
                                  : (AW'(BANK_WORDS) + AW'(read_pos_ff));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= word;
      end
      if (rd_en) begin
         mem_q_ff <= store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_bank_ff  <= 1'b0;
         write_pos_ff   <= '0;
         read_pos_ff    <= '0;
         prev_ready_ff  <= 1'b0;
         frame_ended_ff <= 1'b0;
         bin_sum_ff     <= '0;
         group_count_ff <= '0;
         s1_valid_ff    <= 1'b0;
      end else begin
         write_bank_ff  <= write_bank_in;
         write_pos_ff   <= write_pos_in;
         read_pos_ff    <= read_pos_in;
         prev_ready_ff  <= prev_ready_in;
         frame_ended_ff <= frame_ended_in;
         bin_sum_ff     <= bin_sum_in;
         group_count_ff <= group_count_in;
         s1_valid_ff    <= s1_valid_in;
      end
      s1_from_mem_ff <= s1_from_mem_in;
      s1_oob_ff      <= s1_oob_in;
      s1_pixel_ff    <= s1_pixel_in;
      s1_last_ff     <= s1_last_in;
   end

   always_comb begin
      push_item.last  = s1_last_ff;
      push_item.pixel = s1_pixel_ff;
      if (s1_from_mem_ff) begin
         push_item.pixel = s1_oob_ff ? 16'd0 : mem_q_ff;
      end
   end

   assign rsp_valid = count_ff != 3'd0;
   assign rsp_data  = rsp_q_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign count_in  = count_ff + {2'd0, s1_valid_ff} - {2'd0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (s1_valid_ff) begin
            wr_ptr_ff <= wr_ptr_ff + 2'd1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 2'd1;
         end
         count_ff <= count_in;
      end
      if (s1_valid_ff) begin
         rsp_q_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
